// ===== rtl/pinned_lru_block_cache_directory_defines.svh =====
// Assertion macros for the block cache directory.
`ifndef PINNED_LRU_BLOCK_CACHE_DIRECTORY_DEFINES_SVH
`define PINNED_LRU_BLOCK_CACHE_DIRECTORY_DEFINES_SVH
`ifndef SYNTHESIS
`define PLC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define PLC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PLC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define PLC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/plc_pkg.sv =====
// Shared types and codes of the block cache directory.
`default_nettype none
package plc_pkg;
    localparam int unsigned CAPACITY_DEF = 64;
    localparam int unsigned SLOT_W = 6;

    localparam logic [2:0] K_ACQUIRE   = 3'd0;
    localparam logic [2:0] K_RELEASE   = 3'd1;
    localparam logic [2:0] K_DIRTY     = 3'd2;
    localparam logic [2:0] K_FILL      = 3'd3;
    localparam logic [2:0] K_WRITEBACK = 3'd4;

    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_MISS   = 2'd1;
    localparam logic [1:0] ST_PINNED = 2'd2;
    localparam logic [1:0] ST_ABSENT = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic start;   // load word, begin scan
        logic step;    // visit one entry
        logic commit;  // apply update
        logic age;     // age pass over one entry
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic last;    // final entry of a pass is being processed
    } t_stat;
endpackage
`default_nettype wire

// ===== rtl/plc_datapath.sv =====
// Entry store, scan unit and update logic of the block cache directory.
`default_nettype none
`include "pinned_lru_block_cache_directory_defines.svh"
module plc_datapath #(
    parameter int unsigned CAPACITY = plc_pkg::CAPACITY_DEF,
    localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire plc_pkg::t_cmd i_cmd,
    output plc_pkg::t_stat     o_stat,
    input  wire logic [2:0]    i_kind,
    input  wire logic [31:0]   i_block,
    output logic [1:0]         o_status,
    output logic [5:0]         o_slot,
    output logic               o_need_fill,
    output logic               o_evict_valid,
    output logic [31:0]        o_evict_block,
    output logic               o_evict_writeback
);
    // per-entry state; valid bits reset, the rest is memory
    logic [CAPACITY-1:0] r_valid;
    logic [31:0]   r_blk  [CAPACITY];
    logic [7:0]    r_pin  [CAPACITY];
    logic          r_dirty[CAPACITY];
    logic          r_fill [CAPACITY];
    logic [IW-1:0] r_rank [CAPACITY];

    logic [2:0]  r_kind;
    logic [31:0] r_key;
    logic [IW-1:0] r_idx;
    // read stage: registered fields of entry r_pidx
    logic          r_p;
    logic [IW-1:0] r_pidx;
    logic [31:0]   r_rd_blk;
    logic [7:0]    r_rd_pin;
    logic          r_rd_dirty, r_rd_fill;
    logic [IW-1:0] r_rd_rank;
    // scan results
    logic          r_hit, r_free, r_vic;
    logic [IW-1:0] r_hit_i, r_free_i, r_vic_i, r_vic_rank;
    logic [7:0]    r_hit_pin;
    logic          r_hit_fill;
    logic [IW-1:0] r_hit_rank;
    logic [31:0]   r_vic_blk;
    logic          r_vic_wb;
    // chosen entry and mode for the age pass
    logic [IW-1:0] r_e, r_erank;
    logic          r_ewas;
    logic          r_aging;

    logic [IW-1:0] w_last_idx;
    assign w_last_idx = IW'(CAPACITY - 1);
    assign o_stat.last = r_p && (r_pidx == w_last_idx);

    // read one entry per cycle at the scan index
    always_ff @(posedge i_clk) begin
        r_rd_blk   <= r_blk[r_idx];
        r_rd_pin   <= r_pin[r_idx];
        r_rd_dirty <= r_dirty[r_idx];
        r_rd_fill  <= r_fill[r_idx];
        r_rd_rank  <= r_rank[r_idx];
    end

    // scan one entry per cycle: match, first free, oldest unpinned
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_kind <= i_kind;
            r_key  <= i_block;
            r_idx  <= '0;
            r_p    <= 1'b0;
            r_hit  <= 1'b0;
            r_free <= 1'b0;
            r_vic  <= 1'b0;
        end else if (i_cmd.step || i_cmd.age) begin
            if (r_idx != w_last_idx) r_idx <= r_idx + 1'b1;
            r_p    <= 1'b1;
            r_pidx <= r_idx;
            if (i_cmd.step && r_p) begin
                if (r_valid[r_pidx] && r_rd_blk == r_key && !r_hit) begin
                    r_hit      <= 1'b1;
                    r_hit_i    <= r_pidx;
                    r_hit_pin  <= r_rd_pin;
                    r_hit_fill <= r_rd_fill;
                    r_hit_rank <= r_rd_rank;
                end
                if (!r_valid[r_pidx] && !r_free) begin
                    r_free   <= 1'b1;
                    r_free_i <= r_pidx;
                end
                if (r_valid[r_pidx] && r_rd_pin == 8'd0 &&
                    (!r_vic || r_rd_rank > r_vic_rank)) begin
                    r_vic      <= 1'b1;
                    r_vic_i    <= r_pidx;
                    r_vic_rank <= r_rd_rank;
                    r_vic_blk  <= r_rd_blk;
                    r_vic_wb   <= r_rd_dirty && r_rd_fill;
                end
            end
        end else if (i_cmd.commit) begin
            r_idx <= '0;
            r_p   <= 1'b0;
        end
    end

    // commit: pick entry, update fields, form the result word
    logic          w_acq, w_alloc;
    logic [IW-1:0] w_e;
    always_comb begin
        w_acq   = (r_kind == plc_pkg::K_ACQUIRE);
        w_alloc = w_acq && !r_hit && (r_free || r_vic);
        w_e     = r_hit ? r_hit_i : (r_free ? r_free_i : r_vic_i);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_aging <= 1'b0;
        end else if (i_cmd.commit) begin
            r_aging <= 1'b0;
            o_status          <= plc_pkg::ST_ABSENT;
            o_slot            <= '0;
            o_need_fill       <= 1'b0;
            o_evict_valid     <= 1'b0;
            o_evict_block     <= '0;
            o_evict_writeback <= 1'b0;
            r_e     <= w_e;
            r_erank <= r_hit ? r_hit_rank : r_vic_rank;
            r_ewas  <= r_hit || !r_free;
            if (w_acq && r_hit) begin
                if (r_hit_pin != 8'hFF) r_pin[w_e] <= r_hit_pin + 8'd1;
                r_aging     <= 1'b1;
                o_status    <= plc_pkg::ST_DONE;
                o_slot      <= 6'(w_e);
                o_need_fill <= !r_hit_fill;
            end else if (w_alloc) begin
                r_aging       <= 1'b1;
                r_valid[w_e]  <= 1'b1;
                r_blk[w_e]    <= r_key;
                r_pin[w_e]    <= 8'd1;
                r_dirty[w_e]  <= 1'b0;
                r_fill[w_e]   <= 1'b0;
                o_status      <= plc_pkg::ST_MISS;
                o_slot        <= 6'(w_e);
                o_need_fill   <= 1'b1;
                if (!r_free) begin
                    o_evict_valid     <= 1'b1;
                    o_evict_block     <= r_vic_blk;
                    o_evict_writeback <= r_vic_wb;
                end
            end else if (w_acq) begin
                o_status <= plc_pkg::ST_PINNED;
            end else if (r_hit && r_kind <= plc_pkg::K_WRITEBACK) begin
                o_status    <= plc_pkg::ST_DONE;
                o_slot      <= 6'(w_e);
                o_need_fill <= !(r_hit_fill || r_kind == plc_pkg::K_FILL);
                case (r_kind)
                    plc_pkg::K_RELEASE:
                        if (r_hit_pin != 8'd0) r_pin[w_e] <= r_hit_pin - 8'd1;
                    plc_pkg::K_DIRTY:     r_dirty[w_e] <= 1'b1;
                    plc_pkg::K_FILL:      r_fill[w_e]  <= 1'b1;
                    plc_pkg::K_WRITEBACK: r_dirty[w_e] <= 1'b0;
                    default: ;
                endcase
            end
        end else if (i_cmd.age && r_aging && r_p) begin
            // age pass: one entry per cycle from the read stage
            if (r_pidx == r_e) begin
                r_rank[r_pidx] <= '0;
            end else if (r_valid[r_pidx] && (!r_ewas || r_rd_rank < r_erank)) begin
                r_rank[r_pidx] <= r_rd_rank + 1'b1;
            end
        end
    end

    `PLC_ASSERT_NXT(a_alloc_valid, i_clk, i_rst_n, i_cmd.commit && w_alloc, r_valid[r_e], "allocated entry not valid")
    `PLC_ASSERT_IMP(a_one_cmd, i_clk, i_rst_n, 1'b1, $onehot0(i_cmd), "more than one command")
    `PLC_ASSERT_NXT(a_hit_kept, i_clk, i_rst_n, i_cmd.step && !i_cmd.start && r_hit, r_hit, "hit lost during scan")
endmodule
`default_nettype wire

// ===== rtl/plc_ctrl.sv =====
// Sequencer of the block cache directory.
`default_nettype none
`include "pinned_lru_block_cache_directory_defines.svh"
module plc_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    output logic                o_valid,
    input  wire logic           i_ready,
    output plc_pkg::t_cmd       o_cmd,
    input  wire plc_pkg::t_stat i_stat
);
    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_COMMIT, S_AGE, S_OUT} t_state;
    t_state r_state;
    logic   r_ovalid;

    assign o_valid = r_ovalid;
    // accept a new word once the previous result is gone
    assign o_ready = (r_state == S_IDLE) && !r_ovalid;

    always_comb begin
        o_cmd        = '0;
        o_cmd.start  = i_valid && o_ready;
        o_cmd.step   = (r_state == S_SCAN);
        o_cmd.commit = (r_state == S_COMMIT);
        o_cmd.age    = (r_state == S_AGE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE:   if (i_valid && o_ready) r_state <= S_SCAN;
                S_SCAN:   if (i_stat.last) r_state <= S_COMMIT;
                S_COMMIT: r_state <= S_AGE;
                S_AGE:    if (i_stat.last) r_state <= S_OUT;
                S_OUT: begin
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default:  r_state <= S_IDLE;
            endcase
        end
    end

    `PLC_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, r_ovalid && !i_ready, r_ovalid, "result dropped")
    `PLC_ASSERT_IMP(a_no_take, i_clk, i_rst_n, r_ovalid, !o_ready, "input taken with result pending")
    `PLC_ASSERT_NXT(a_start_scan, i_clk, i_rst_n, o_cmd.start, r_state == S_SCAN, "scan not started")
endmodule
`default_nettype wire

// ===== rtl/pinned_lru_block_cache_directory.sv =====
// Top level of the pinned LRU block cache directory.
// Input channel: i_valid/o_ready with i_kind and i_block, one word per request.
// Output channel: o_valid/i_ready with status, slot, need_fill and evict fields.
// Each request scans all CAPACITY entries one per cycle (lookup, free entry,
// oldest unpinned victim) through a registered read, commits, then runs a
// second pass that updates recency ranks, one entry per cycle; the S_OUT
// state then raises o_valid.
// The next request is taken once the result word has been taken.
// Reset clears all valid bits at once; no clearing pass is needed.
// A stalled receiver holds the result word and blocks new requests.
`default_nettype none
module pinned_lru_block_cache_directory #(
    parameter int unsigned CAPACITY = plc_pkg::CAPACITY_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [2:0]  i_kind,
    input  wire logic [31:0] i_block,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [1:0]       o_status,
    output logic [5:0]       o_slot,
    output logic             o_need_fill,
    output logic             o_evict_valid,
    output logic [31:0]      o_evict_block,
    output logic             o_evict_writeback
);
    plc_pkg::t_cmd  w_cmd;
    plc_pkg::t_stat w_stat;

    plc_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .o_valid(o_valid), .i_ready(i_ready), .o_cmd(w_cmd), .i_stat(w_stat)
    );

    plc_datapath #(.CAPACITY(CAPACITY)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_stat(w_stat),
        .i_kind(i_kind), .i_block(i_block), .o_status(o_status), .o_slot(o_slot),
        .o_need_fill(o_need_fill), .o_evict_valid(o_evict_valid),
        .o_evict_block(o_evict_block), .o_evict_writeback(o_evict_writeback)
    );
endmodule
`default_nettype wire

// ===== tb/pinned_lru_block_cache_directory_tb.sv =====
// Testbench for the pinned LRU block cache directory: directed and random requests.
`default_nettype none
module pinned_lru_block_cache_directory_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NENT = 64;
    localparam int LAT = 2 * NENT + 6;
    localparam longint CYCLE_LIMIT = 64'd3_000_000;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  slot;
        logic        need_fill;
        logic        evict_valid;
        logic [31:0] evict_block;
        logic        evict_writeback;
    } t_word;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [2:0]  i_kind;
    logic [31:0] i_block;
    logic        o_valid;
    logic        i_ready;
    logic [1:0]  o_status;
    logic [5:0]  o_slot;
    logic        o_need_fill;
    logic        o_evict_valid;
    logic [31:0] o_evict_block;
    logic        o_evict_writeback;

    // shadow directory
    bit          dir_valid [NENT];
    logic [31:0] dir_block [NENT];
    logic [7:0]  dir_pins [NENT];
    bit          dir_dirty [NENT];
    bit          dir_filled [NENT];
    int          dir_rank [NENT];

    t_word       pending_words [$];
    int          mismatch_count;
    longint      cycle_count;
    bit          rx_quiet;
    logic [31:0] block_pool [16];

    pinned_lru_block_cache_directory u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_kind(i_kind), .i_block(i_block), .o_valid(o_valid), .i_ready(i_ready),
        .o_status(o_status), .o_slot(o_slot), .o_need_fill(o_need_fill),
        .o_evict_valid(o_evict_valid), .o_evict_block(o_evict_block),
        .o_evict_writeback(o_evict_writeback)
    );

    // 12 ns clock
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // count cycles, stop a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic int find_entry(logic [31:0] blk);
        for (int i = 0; i < NENT; i++)
            if (dir_valid[i] && dir_block[i] == blk) return i;
        return -1;
    endfunction

    // move entry to most recent; a fresh entry ages every valid one
    function automatic void promote_entry(int e, bit was_valid);
        int r;
        r = dir_rank[e];
        for (int i = 0; i < NENT; i++) begin
            if (i == e || !dir_valid[i]) continue;
            if (!was_valid || dir_rank[i] < r) dir_rank[i] = dir_rank[i] + 1;
        end
        dir_rank[e] = 0;
    endfunction

    // apply one request to the shadow and return the result word
    function automatic t_word apply_request(logic [2:0] kind, logic [31:0] blk);
        t_word w;
        int e;
        int best;
        bit was_valid;
        w = '0;
        w.status = plc_pkg::ST_ABSENT;
        e = -1;
        was_valid = 0;
        if (kind == plc_pkg::K_ACQUIRE) begin
            e = find_entry(blk);
            if (e >= 0) begin
                if (dir_pins[e] != 8'hFF) dir_pins[e]++;
                promote_entry(e, 1'b1);
                w.status = plc_pkg::ST_DONE;
            end else begin
                for (int i = 0; i < NENT; i++)
                    if (!dir_valid[i]) begin
                        e = i;
                        break;
                    end
                if (e < 0) begin
                    best = -1;
                    for (int i = 0; i < NENT; i++)
                        if (dir_pins[i] == 0 && (best < 0 || dir_rank[i] > dir_rank[best]))
                            best = i;
                    if (best >= 0) begin
                        e = best;
                        was_valid = 1;
                        w.evict_valid = 1'b1;
                        w.evict_block = dir_block[e];
                        w.evict_writeback = dir_dirty[e] && dir_filled[e];
                    end
                end
                if (e < 0) begin
                    w.status = plc_pkg::ST_PINNED;
                end else begin
                    promote_entry(e, was_valid);
                    dir_valid[e] = 1;
                    dir_block[e] = blk;
                    dir_pins[e] = 8'd1;
                    dir_dirty[e] = 0;
                    dir_filled[e] = 0;
                    w.status = plc_pkg::ST_MISS;
                end
            end
        end else if (kind <= plc_pkg::K_WRITEBACK) begin
            e = find_entry(blk);
            if (e >= 0) begin
                case (kind)
                    plc_pkg::K_RELEASE: if (dir_pins[e] != 0) dir_pins[e]--;
                    plc_pkg::K_DIRTY: dir_dirty[e] = 1;
                    plc_pkg::K_FILL: dir_filled[e] = 1;
                    default: dir_dirty[e] = 0;
                endcase
                w.status = plc_pkg::ST_DONE;
            end
        end
        if (e >= 0 && (w.status == plc_pkg::ST_DONE || w.status == plc_pkg::ST_MISS)) begin
            w.slot = e[5:0];
            w.need_fill = !dir_filled[e];
        end
        return w;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycle_count);
        mismatch_count++;
    endtask

    // send one word; gap drawn per word, valid low through the gap only
    task automatic send_request(logic [2:0] kind, logic [31:0] blk);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_kind <= kind;
        i_block <= blk;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pending_words.push_back(apply_request(kind, blk));
        @(negedge i_clk);
    endtask

    // receiver stall and result check
    initial begin
        int stall;
        t_word want;
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            stall = rx_quiet ? 0 : $urandom_range(0, 18);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (o_valid !== 1'b1) @(posedge i_clk);
            if (pending_words.size() == 0) begin
                report_mismatch("unexpected word", o_status, 0);
            end else begin
                want = pending_words.pop_front();
                if (o_status !== want.status) report_mismatch("status", o_status, want.status);
                if (o_slot !== want.slot) report_mismatch("slot", o_slot, want.slot);
                if (o_need_fill !== want.need_fill)
                    report_mismatch("need_fill", o_need_fill, want.need_fill);
                if (o_evict_valid !== want.evict_valid)
                    report_mismatch("evict_valid", o_evict_valid, want.evict_valid);
                if (o_evict_block !== want.evict_block)
                    report_mismatch("evict_block", o_evict_block, want.evict_block);
                if (o_evict_writeback !== want.evict_writeback)
                    report_mismatch("evict_writeback", o_evict_writeback,
                                    want.evict_writeback);
            end
        end
    end

    // extremes, every kind, absent blocks, unknown kinds, pin floor
    task automatic test_directed();
        send_request(plc_pkg::K_RELEASE, 32'h0);
        send_request(plc_pkg::K_ACQUIRE, 32'h0);
        send_request(plc_pkg::K_ACQUIRE, 32'hFFFF_FFFF);
        send_request(plc_pkg::K_ACQUIRE, 32'hFFFF_FFFF);
        send_request(plc_pkg::K_DIRTY, 32'h0);
        send_request(plc_pkg::K_FILL, 32'h0);
        send_request(plc_pkg::K_WRITEBACK, 32'h0);
        send_request(plc_pkg::K_RELEASE, 32'h0);
        send_request(plc_pkg::K_RELEASE, 32'h0);
        send_request(plc_pkg::K_DIRTY, 32'h5555_AAAA);
        send_request(plc_pkg::K_FILL, 32'hAAAA_5555);
        send_request(plc_pkg::K_WRITEBACK, 32'h1234_5678);
        send_request(3'd5, 32'h0);
        send_request(3'd6, 32'hFFFF_FFFF);
        send_request(3'd7, 32'h0);
        send_request(plc_pkg::K_WRITEBACK, 32'hFFFF_FFFF);
    endtask

    // pin saturation at 255, then drain back to zero
    task automatic test_pin_saturation();
        repeat (258) send_request(plc_pkg::K_ACQUIRE, 32'hFFFF_FFFF);
        repeat (258) send_request(plc_pkg::K_RELEASE, 32'hFFFF_FFFF);
    endtask

    // fill the store, pin all, then evict with dirty and filled mixes
    task automatic test_full_store();
        for (int i = 0; i < NENT; i++) send_request(plc_pkg::K_ACQUIRE, 32'h100 + i);
        send_request(plc_pkg::K_ACQUIRE, 32'hDEAD_0000);
        for (int i = 0; i < NENT; i += 3) begin
            send_request(plc_pkg::K_RELEASE, 32'h100 + i);
            if (i % 2 == 0) send_request(plc_pkg::K_DIRTY, 32'h100 + i);
            if (i % 4 == 0) send_request(plc_pkg::K_FILL, 32'h100 + i);
        end
        for (int i = 0; i < 24; i++) begin
            send_request(plc_pkg::K_ACQUIRE, 32'h200 + i);
            send_request(plc_pkg::K_RELEASE, 32'h200 + i);
        end
    endtask

    // random traffic over a small pool of blocks so hits and evictions are frequent
    task automatic test_random(int count);
        int pick;
        logic [31:0] blk;
        for (int i = 0; i < 16; i++) block_pool[i] = $urandom;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 9) == 0) blk = $urandom;
            else if ($urandom_range(0, 1)) blk = block_pool[$urandom_range(0, 15)];
            else blk = 32'h100 + $urandom_range(0, 95);
            pick = $urandom_range(0, 99);
            if (pick < 40) send_request(plc_pkg::K_ACQUIRE, blk);
            else if (pick < 70) send_request(plc_pkg::K_RELEASE, blk);
            else if (pick < 80) send_request(plc_pkg::K_DIRTY, blk);
            else if (pick < 90) send_request(plc_pkg::K_FILL, blk);
            else if (pick < 97) send_request(plc_pkg::K_WRITEBACK, blk);
            else send_request(3'($urandom_range(5, 7)), blk);
            if (i % 200 == 100) rx_quiet = !rx_quiet;
        end
    endtask

    initial begin
        int waited;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_kind = plc_pkg::K_ACQUIRE;
        i_block = '0;
        cycle_count = 0;
        mismatch_count = 0;
        rx_quiet = 0;
        for (int i = 0; i < NENT; i++) begin
            dir_valid[i] = 0;
            dir_rank[i] = 0;
            dir_pins[i] = 0;
        end
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_pin_saturation();
        test_full_store();
        test_random(766);
        i_valid <= 1'b0;
        waited = 0;
        while (pending_words.size() != 0 && waited < 100 * LAT) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (LAT) @(negedge i_clk);
        if (mismatch_count == 0 && pending_words.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
`default_nettype wire
